/* rtl/histogram_density_range_picker_assert.svh */
// Assertion macros shared by the histogram density range picker RTL.
`ifndef HISTOGRAM_DENSITY_RANGE_PICKER_ASSERT_SVH
`define HISTOGRAM_DENSITY_RANGE_PICKER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HDRP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hdrp assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define HDRP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hdrp assertion failed");

`endif

/* rtl/hdrp_pkg.sv */
// Shared types and constants of the histogram density range picker.
package hdrp_pkg;

  // Number of histogram bins; the edge and budget arithmetic relies on a power of two.
  localparam int NUM_BINS = 64;

  // Operation codes of an input beat.
  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_QUERY = 2'd2
  } op_e;

  // Configuration register indexes.
  localparam logic CFG_RANGE_LOW  = 1'b0;
  localparam logic CFG_RANGE_HIGH = 1'b1;

  // Share test scale (100 percent times Q8.8) and budget divisor (Q8.8 times 10).
  localparam int unsigned SHARE_SCALE = 25600;
  localparam int unsigned BUDGET_DIV  = 2560;

  // Status of the serial divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* rtl/hdrp_div.sv */
// Radix-2 restoring divider for unsigned operands, one quotient bit per cycle.
module hdrp_div import hdrp_pkg::*; #(
  parameter int DW = 40
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output div_stat_t     stat_o,
  output logic [DW-1:0] quotient_o
);

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] quo_q;
  logic [DW-1:0] rem_q;
  logic [DW-1:0] den_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;
  logic [DW:0]   shifted;
  logic          fits;

  // Trial subtraction of the divisor from the shifted remainder.
  assign shifted = {rem_q, quo_q[DW-1]};
  assign fits    = shifted >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Operand and partial result registers.
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? DW'(shifted - {1'b0, den_q}) : shifted[DW-1:0];
      quo_q <= {quo_q[DW-2:0], fits};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;

endmodule

/* rtl/histogram_density_range_picker.sv */
// Top level: histogram store, binning, query budget and density walk.
//
// Channel   Direction  Handshake               Payload
// input     in         start high, busy low    operation_i, sample_value_i, expansion_ratio_i
// result    out        done_o for one cycle    left_bin_o, right_bin_o, left_edge_o, right_edge_o
// config    in         cfg_we_i                cfg_idx_i, cfg_data_i
//
// One item at a time; busy stays high from the accepting edge until the block is idle again.
// Binning runs on the serial divider (DW = 32 + clog2(NUM_BINS+1), 39 bits at 64 bins), or is
// done directly when the range ends are equal or the offset is zero or of opposite sign.
// An add then reads and updates its bin; a clear zeroes every bin in turn. A query bins, sets
// its budget, walks left and then right with a check per bin, and computes both edges.
// After reset a clearing pass runs with busy high. Results cannot be held off by the receiver:
// each is shown for one cycle.
`include "histogram_density_range_picker_assert.svh"

module histogram_density_range_picker import hdrp_pkg::*; #(
  parameter int COUNT_WIDTH = 20
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         operation_i,
  input  logic signed [31:0] sample_value_i,
  input  logic [15:0]        expansion_ratio_i,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  output logic               done_o,
  output logic [5:0]         left_bin_o,
  output logic [5:0]         right_bin_o,
  output logic signed [31:0] left_edge_o,
  output logic signed [31:0] right_edge_o
);

  localparam int BW    = $clog2(NUM_BINS);
  localparam int LW    = $clog2(NUM_BINS + 1);
  localparam int DW    = 32 + LW;
  localparam int SW    = LW + 6;
  localparam int AW    = COUNT_WIDTH + 17;
  localparam int BIG   = NUM_BINS * 35 / 100;
  localparam int SMALL = NUM_BINS / 10;
  localparam int HALF  = NUM_BINS / 2;

  // The budget divisor 2560 is 512 times 5: a shift, then a reciprocal multiply by 1/5
  // that is exact for the operand sizes seen here.
  localparam int BUD_SHIFT   = 9;
  localparam int RECIP_FIVE  = 52429;
  localparam int RECIP_SHIFT = 18;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_BIN, S_BIN_W, S_ADD_RD, S_ADD_WR,
    S_BUD1, S_BUD2, S_BUD2_W,
    S_WALK_L, S_CHK_L, S_WALK_R, S_CHK_R,
    S_EDGE_L, S_EDGE_L_W, S_EDGE_R, S_EDGE_R_W
  } state_e;

  state_e                  state_q;
  logic signed [31:0]      range_low_q, range_high_q;
  logic [COUNT_WIDTH-1:0]  total_q;
  logic [1:0]              op_q;
  logic signed [31:0]      val_q;
  logic [15:0]             ratio_q;
  logic [BW-1:0]           clr_q, bin_q, left_q, right_q;
  logic [LW-1:0]           road_q;
  logic [11:0]             bud_q;
  logic [SW-1:0]           budget_q, side_q;
  logic [COUNT_WIDTH+15:0] limit_q;
  logic [AW-1:0]           acc_q;
  logic [DW-1:0]           prod_q;
  logic                    done_q;
  logic [5:0]              lbin_q, rbin_q;
  logic signed [31:0]      ledge_q, redge_q;

  logic [COUNT_WIDTH-1:0]  cnt_mem [NUM_BINS];
  logic [COUNT_WIDTH-1:0]  rd_q;
  logic                    mem_we;
  logic [BW-1:0]           mem_wa, mem_ra;
  logic [COUNT_WIDTH-1:0]  mem_wd, rd_inc;

  logic                    div_go;
  logic [DW-1:0]           div_a, div_b, div_q;
  div_stat_t               div_stat;

  logic signed [32:0]      wid, num;
  logic                    wid_neg, num_neg, wid_zero, bin_trivial;
  logic [31:0]             wid_mag, num_mag, ofs_mag, edge_ofs;
  logic [LW-1:0]           ctr_gap;
  logic [11:0]             taper;
  logic [AW-1:0]           cand;
  logic [BW-1:0]           bin_clamped;

  // Range width and sample offset, with signs and magnitudes.
  assign wid         = 33'(range_high_q) - 33'(range_low_q);
  assign num         = 33'(val_q) - 33'(range_low_q);
  assign wid_neg     = wid[32];
  assign num_neg     = num[32];
  assign wid_zero    = wid == '0;
  assign bin_trivial = (num == '0) || (num_neg != wid_neg);
  assign wid_mag     = wid_neg ? 32'(-wid) : wid[31:0];
  assign num_mag     = num_neg ? 32'(-num) : num[31:0];

  // Distance of the centre bin from the middle, and the rounded-up taper of the budget.
  assign ctr_gap = (LW'(HALF) >= LW'(bin_q)) ? LW'(HALF) - LW'(bin_q)
                                             : LW'(bin_q) - LW'(HALF);
  assign taper   = (12'(BIG - SMALL) * 12'(ctr_gap) + 12'(HALF - 1)) / 12'(HALF);

  // Scaled share of the walk sum with the new bin included.
  assign cand = acc_q + AW'(rd_q) * AW'(SHARE_SCALE);

  assign bin_clamped = (div_q >= DW'(NUM_BINS)) ? BW'(NUM_BINS - 1) : div_q[BW-1:0];
  assign rd_inc      = (rd_q == '1) ? rd_q : rd_q + 1'b1;

  // Bin edge offset: the width times the index, divided by the bin count, toward zero.
  assign ofs_mag  = prod_q[BW+31:BW];
  assign edge_ofs = wid_neg ? -ofs_mag : ofs_mag;

  // Memory port control.
  always_comb begin
    mem_ra = bin_q;
    if (state_q == S_WALK_L) begin
      mem_ra = left_q - 1'b1;
    end else if (state_q == S_WALK_R) begin
      mem_ra = right_q + 1'b1;
    end
    mem_we = (state_q == S_CLR) || (state_q == S_ADD_WR);
    mem_wa = (state_q == S_CLR) ? clr_q : bin_q;
    mem_wd = (state_q == S_CLR) ? '0 : rd_inc;
  end

  // The divider only bins: offset times the bin count over the range width.
  assign div_go = (state_q == S_BIN) && !wid_zero && !bin_trivial;
  assign div_a  = DW'(num_mag) * DW'(NUM_BINS);
  assign div_b  = DW'(wid_mag);

  hdrp_div #(.DW(DW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_go),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .stat_o     (div_stat),
    .quotient_o (div_q)
  );

  // Bin count memory with registered read data.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      cnt_mem[mem_wa] <= mem_wd;
    end
    rd_q <= cnt_mem[mem_ra];
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_low_q  <= 32'sd0;
      range_high_q <= 32'sd65536;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_RANGE_LOW) begin
        range_low_q <= cfg_data_i;
      end else begin
        range_high_q <= cfg_data_i;
      end
    end
  end

  // Sequencer and its registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_q   <= '0;
      total_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_CLR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == BW'(NUM_BINS - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            op_q    <= operation_i;
            val_q   <= sample_value_i;
            ratio_q <= expansion_ratio_i;
            case (operation_i)
              OP_CLEAR: begin
                total_q <= '0;
                clr_q   <= '0;
                state_q <= S_CLR;
              end
              OP_ADD, OP_QUERY: begin
                state_q <= S_BIN;
              end
              default: begin
                state_q <= S_IDLE;
              end
            endcase
          end
        end
        S_BIN: begin
          if (wid_zero || bin_trivial) begin
            bin_q   <= wid_zero ? BW'(HALF) : '0;
            state_q <= (op_q == OP_ADD) ? S_ADD_RD : S_BUD1;
          end else begin
            state_q <= S_BIN_W;
          end
        end
        S_BIN_W: begin
          if (div_stat.done) begin
            bin_q   <= bin_clamped;
            state_q <= (op_q == OP_ADD) ? S_ADD_RD : S_BUD1;
          end
        end
        S_ADD_RD: begin
          state_q <= S_ADD_WR;
        end
        S_ADD_WR: begin
          if (total_q != '1) begin
            total_q <= total_q + 1'b1;
          end
          state_q <= S_IDLE;
        end
        S_BUD1: begin
          limit_q <= (COUNT_WIDTH + 16)'(ratio_q) * (COUNT_WIDTH + 16)'(total_q);
          road_q  <= (taper > 12'(BIG)) ? '0 : LW'(12'(BIG) - taper);
          state_q <= S_BUD2;
        end
        S_BUD2: begin
          bud_q   <= 12'((23'(road_q) * 23'(ratio_q)) >> BUD_SHIFT);
          state_q <= S_BUD2_W;
        end
        S_BUD2_W: begin
          budget_q <= SW'((28'(bud_q) * 28'(RECIP_FIVE)) >> RECIP_SHIFT);
          side_q   <= SW'((28'(bud_q) * 28'(RECIP_FIVE)) >> RECIP_SHIFT);
          left_q   <= bin_q;
          right_q  <= bin_q;
          acc_q    <= '0;
          state_q  <= S_WALK_L;
        end
        S_WALK_L: begin
          if (side_q == '0 || left_q == '0) begin
            side_q  <= budget_q;
            acc_q   <= '0;
            state_q <= S_WALK_R;
          end else begin
            left_q  <= left_q - 1'b1;
            side_q  <= side_q - 1'b1;
            state_q <= S_CHK_L;
          end
        end
        S_CHK_L: begin
          if (cand <= AW'(limit_q)) begin
            acc_q   <= cand;
            state_q <= S_WALK_L;
          end else begin
            side_q  <= budget_q;
            acc_q   <= '0;
            state_q <= S_WALK_R;
          end
        end
        S_WALK_R: begin
          if (side_q == '0 || right_q == BW'(NUM_BINS - 1)) begin
            state_q <= S_EDGE_L;
          end else begin
            right_q <= right_q + 1'b1;
            side_q  <= side_q - 1'b1;
            state_q <= S_CHK_R;
          end
        end
        S_CHK_R: begin
          if (cand <= AW'(limit_q)) begin
            acc_q   <= cand;
            state_q <= S_WALK_R;
          end else begin
            state_q <= S_EDGE_L;
          end
        end
        S_EDGE_L: begin
          prod_q  <= DW'(wid_mag) * DW'(left_q);
          state_q <= S_EDGE_L_W;
        end
        S_EDGE_L_W: begin
          ledge_q <= range_low_q + $signed(edge_ofs);
          state_q <= S_EDGE_R;
        end
        S_EDGE_R: begin
          prod_q  <= DW'(wid_mag) * (DW'(right_q) + DW'(1));
          state_q <= S_EDGE_R_W;
        end
        S_EDGE_R_W: begin
          redge_q <= range_low_q + $signed(edge_ofs);
          lbin_q  <= 6'(left_q);
          rbin_q  <= 6'(right_q);
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy         = state_q != S_IDLE;
  assign done_o       = done_q;
  assign left_bin_o   = lbin_q;
  assign right_bin_o  = rbin_q;
  assign left_edge_o  = ledge_q;
  assign right_edge_o = redge_q;

  // An accepted add keeps the block busy in the next cycle.
  `HDRP_ASSERT_NEXT(a_add_busy, clk_i, rst_ni, start && !busy && operation_i == OP_ADD, busy)
  // The divider is only started while it is idle.
  `HDRP_ASSERT_NOW(a_div_idle, clk_i, rst_ni, div_go, !div_stat.busy)
  // The walk never crosses the centre bin.
  `HDRP_ASSERT_NOW(a_walk_span, clk_i, rst_ni, state_q == S_CHK_L || state_q == S_CHK_R, left_q <= bin_q && right_q >= bin_q)
  // A result beat lasts one cycle.
  `HDRP_ASSERT_NEXT(a_done_pulse, clk_i, rst_ni, done_o, !done_o)

endmodule
